FILE: sv/pfp_pkg.sv
// Package: shared constants, types and helper functions for the packet parser.
`timescale 1ns / 1ps

package pfp_pkg;

    // Descriptor limit per packet and derived widths
    localparam int MAX_MESSAGES = 16;
    localparam int MSG_CNT_W    = $clog2(MAX_MESSAGES + 1);
    localparam int MSG_ADDR_W   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int RAM_ADDR_W   = MSG_ADDR_W + 1;
    localparam int RAM_DEPTH    = 2 ** RAM_ADDR_W;
    localparam int DESC_W       = 48;

    // Header layout
    localparam logic [15:0] HDR_LEN      = 16'd12;
    localparam logic [15:0] CRC_MIN_SIZE = 16'd16;
    localparam logic [15:0] SIZE_MAX     = 16'hFFFF;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd1;
    localparam logic [2:0] ST_BAD_PREFIX  = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_CRC     = 3'd4;

    // Packet summary handed from the front to the back
    typedef struct packed {
        logic [2:0]           status;
        logic [7:0]           minor;
        logic [15:0]          seq;
        logic [14:0]          count;
        logic [MSG_CNT_W-1:0] num;
        logic                 desc_valid;
        logic                 bank;
    } summary_t;

    // Expected prefix byte at position 0..3
    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h6F;
            2'd1:    r = 8'h67;
            2'd2:    r = 8'h33;
            default: r = 8'h70;
        endcase
        return r;
    endfunction

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/pfp_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pfp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/pfp_queue.sv
// One-entry summary queue between the byte front end and the result back end.
`timescale 1ns / 1ps

module pfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  pfp_pkg::summary_t q_wdata,
    output logic              q_full,
    input  logic              q_pop,
    output pfp_pkg::summary_t q_rdata
);

    logic              occ_reg;
    logic              occ_next;
    pfp_pkg::summary_t data_reg;

    // Occupancy: a pop and a push never coincide (push only when empty)
    always_comb
    begin
        occ_next = occ_reg;
        if (q_pop)
        begin
            occ_next = 1'b0;
        end
        if (q_push)
        begin
            occ_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            data_reg <= q_wdata;
        end
    end

    assign q_full  = occ_reg;
    assign q_rdata = data_reg;

endmodule

FILE: sv/pfp_front.sv
// Front end: byte intake, header checks, CRC, message walk and packet summary.
`timescale 1ns / 1ps

module pfp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      data_byte,
    input  logic                            end_of_buffer,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data,
    output logic                            q_push,
    output pfp_pkg::summary_t               q_wdata,
    input  logic                            q_full,
    output logic                            wr_en,
    output logic [pfp_pkg::RAM_ADDR_W-1:0]  wr_addr,
    output logic [pfp_pkg::DESC_W-1:0]      wr_data
);

    logic [7:0]                    ver_reg;
    logic [15:0]                   cnt_reg, cnt_next;
    logic [15:0]                   size_reg, size_next;
    logic [7:0]                    minor_reg, minor_next;
    logic [15:0]                   seq_reg, seq_next;
    logic [15:0]                   mcnt_reg, mcnt_next;
    logic [1:0]                    flag_reg, flag_next;
    logic [31:0]                   crc_reg, crc_next;
    logic [31:0]                   rx_reg, rx_next;
    logic [17:0]                   off_reg, off_next;
    logic [pfp_pkg::MSG_CNT_W-1:0] widx_reg, widx_next;
    logic                          werr_reg, werr_next;
    logic [15:0]                   doff_reg, doff_next;
    logic [15:0]                   dsize_reg, dsize_next;
    logic [7:0]                    dtype_reg, dtype_next;
    logic                          fin_reg, fin_next;
    logic                          bank_reg, bank_next;

    logic                          acc;
    logic [15:0]                   pos;
    logic                          crc_on;
    logic [14:0]                   msg_cnt;
    logic [pfp_pkg::MSG_CNT_W-1:0] avail;
    logic [18:0]                   off_end;
    logic [1:0]                    rel;
    logic [1:0]                    rx_sh;
    logic [15:0]                   cur_size;
    logic [16:0]                   size_rnd;
    logic [2:0]                    status;
    logic [17:0]                   need;

    assign acc       = push && !full;
    assign full      = fin_reg || q_full;
    assign cfg_ready = 1'b1;
    assign pos       = cnt_reg;

    // Message count and available descriptors
    assign crc_on  = mcnt_reg[15];
    assign msg_cnt = crc_on ? {1'b0, mcnt_reg[13:0]} : mcnt_reg[14:0];
    assign avail   = (32'(msg_cnt) < pfp_pkg::MAX_MESSAGES)
                     ? pfp_pkg::MSG_CNT_W'(msg_cnt)
                     : pfp_pkg::MSG_CNT_W'(pfp_pkg::MAX_MESSAGES);
    assign off_end = {1'b0, off_reg} + 19'd4;
    assign rel     = pos[1:0] - off_reg[1:0];
    assign rx_sh   = pos[1:0] - size_reg[1:0];

    // Final status from the state left by the last byte
    assign need = 18'({msg_cnt, 2'b00}) + 18'(pfp_pkg::HDR_LEN) + (crc_on ? 18'd4 : 18'd0);
    always_comb
    begin
        if (cnt_reg < pfp_pkg::HDR_LEN)
            status = pfp_pkg::ST_BAD_SIZE;
        else if (flag_reg[0])
            status = pfp_pkg::ST_BAD_PREFIX;
        else if (flag_reg[1])
            status = pfp_pkg::ST_BAD_VERSION;
        else if (size_reg > cnt_reg || size_reg < pfp_pkg::HDR_LEN)
            status = pfp_pkg::ST_BAD_SIZE;
        else if (crc_on && size_reg < pfp_pkg::CRC_MIN_SIZE)
            status = pfp_pkg::ST_BAD_SIZE;
        else if (crc_on && (~crc_reg != rx_reg))
            status = pfp_pkg::ST_BAD_CRC;
        else if (need > {2'b00, size_reg})
            status = pfp_pkg::ST_BAD_SIZE;
        else if (werr_reg || widx_reg < avail)
            status = pfp_pkg::ST_BAD_SIZE;
        else
            status = pfp_pkg::ST_OK;
    end

    // Summary toward the back end
    assign q_push             = fin_reg && !q_full;
    assign q_wdata.status     = status;
    assign q_wdata.minor      = minor_reg;
    assign q_wdata.seq        = seq_reg;
    assign q_wdata.count      = msg_cnt;
    assign q_wdata.desc_valid = (status == pfp_pkg::ST_OK) && (avail != '0);
    assign q_wdata.num        = q_wdata.desc_valid ? avail : pfp_pkg::MSG_CNT_W'(1);
    assign q_wdata.bank       = bank_reg;

    // Descriptor store write on the last byte of a message header
    assign cur_size = {dsize_reg[15:8], dsize_reg[7:0]};
    assign size_rnd = ({1'b0, cur_size} + 17'd3) & ~17'd3;
    assign wr_addr  = {bank_reg, widx_reg[pfp_pkg::MSG_ADDR_W-1:0]};
    assign wr_data  = {doff_reg, dsize_reg, dtype_reg, data_byte};

    // Per-byte state update
    always_comb
    begin
        cnt_next   = cnt_reg;
        size_next  = size_reg;
        minor_next = minor_reg;
        seq_next   = seq_reg;
        mcnt_next  = mcnt_reg;
        flag_next  = flag_reg;
        crc_next   = crc_reg;
        rx_next    = rx_reg;
        off_next   = off_reg;
        widx_next  = widx_reg;
        werr_next  = werr_reg;
        doff_next  = doff_reg;
        dsize_next = dsize_reg;
        dtype_next = dtype_reg;
        fin_next   = fin_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;

        if (q_push)
        begin
            cnt_next   = '0;
            size_next  = '0;
            minor_next = '0;
            seq_next   = '0;
            mcnt_next  = '0;
            flag_next  = '0;
            crc_next   = '1;
            rx_next    = '0;
            off_next   = 18'(pfp_pkg::HDR_LEN);
            widx_next  = '0;
            werr_next  = 1'b0;
            fin_next   = 1'b0;
            bank_next  = !bank_reg;
        end
        else if (acc)
        begin
            if (pos != pfp_pkg::SIZE_MAX)
                cnt_next = pos + 16'd1;

            // Header fields
            if (pos < 16'd4)
            begin
                if (data_byte != pfp_pkg::prefix_byte(pos[1:0]))
                    flag_next[0] = 1'b1;
            end
            else
            begin
                case (pos)
                    16'd4:   flag_next[1] = flag_reg[1] | (data_byte != ver_reg);
                    16'd5:   minor_next = data_byte;
                    16'd6:   size_next = {data_byte, 8'h00};
                    16'd7:   size_next = {size_reg[15:8], data_byte};
                    16'd8:   seq_next[15:8] = data_byte;
                    16'd9:   seq_next[7:0] = data_byte;
                    16'd10:  mcnt_next[15:8] = data_byte;
                    16'd11:  mcnt_next[7:0] = data_byte;
                    default: ;
                endcase
            end

            // CRC over header and body, trailing word captured little-endian
            if (pos < pfp_pkg::HDR_LEN || (size_reg >= pfp_pkg::CRC_MIN_SIZE
                && ({1'b0, pos} + 17'd4) < {1'b0, size_reg}))
                crc_next = pfp_pkg::crc_byte(crc_reg, data_byte);
            if (pos >= pfp_pkg::HDR_LEN && size_reg >= pfp_pkg::CRC_MIN_SIZE
                && pos >= size_reg - 16'd4 && pos < size_reg)
            begin
                case (rx_sh)
                    2'd0:    rx_next = rx_reg | {24'd0, data_byte};
                    2'd1:    rx_next = rx_reg | {16'd0, data_byte, 8'd0};
                    2'd2:    rx_next = rx_reg | {8'd0, data_byte, 16'd0};
                    default: rx_next = rx_reg | {data_byte, 24'd0};
                endcase
            end

            // Message header walk
            if (pos >= pfp_pkg::HDR_LEN && !werr_reg && widx_reg < avail
                && {2'b00, pos} >= off_reg && {3'b000, pos} < off_end)
            begin
                case (rel)
                    2'd0:
                    begin
                        if (off_end > {3'b000, size_reg})
                            werr_next = 1'b1;
                        else
                        begin
                            doff_next  = off_end[15:0];
                            dsize_next = {data_byte, 8'h00};
                        end
                    end
                    2'd1:
                    begin
                        dsize_next = {dsize_reg[15:8], data_byte};
                        if (({1'b0, off_reg} + {3'b000, dsize_reg[15:8], data_byte})
                            > {3'b000, size_reg})
                            werr_next = 1'b1;
                    end
                    2'd2:    dtype_next = data_byte;
                    default:
                    begin
                        wr_en     = 1'b1;
                        widx_next = widx_reg + pfp_pkg::MSG_CNT_W'(1);
                        off_next  = 18'(off_end + {2'b00, size_rnd});
                    end
                endcase
            end

            if (end_of_buffer)
                fin_next = 1'b1;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ver_reg <= cfg_data;
        end
    end

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            size_reg  <= '0;
            minor_reg <= '0;
            seq_reg   <= '0;
            mcnt_reg  <= '0;
            flag_reg  <= '0;
            crc_reg   <= '1;
            rx_reg    <= '0;
            off_reg   <= 18'(pfp_pkg::HDR_LEN);
            widx_reg  <= '0;
            werr_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            size_reg  <= size_next;
            minor_reg <= minor_next;
            seq_reg   <= seq_next;
            mcnt_reg  <= mcnt_next;
            flag_reg  <= flag_next;
            crc_reg   <= crc_next;
            rx_reg    <= rx_next;
            off_reg   <= off_next;
            widx_reg  <= widx_next;
            werr_reg  <= werr_next;
            fin_reg   <= fin_next;
            bank_reg  <= bank_next;
        end
    end

    // Descriptor under construction
    always_ff @(posedge clk)
    begin
        doff_reg  <= doff_next;
        dsize_reg <= dsize_next;
        dtype_reg <= dtype_next;
    end

endmodule

FILE: sv/pfp_back.sv
// Back end: walks one packet summary and emits its result items.
`timescale 1ns / 1ps

module pfp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_full,
    output logic                           q_pop,
    input  pfp_pkg::summary_t              q_rdata,
    output logic [pfp_pkg::RAM_ADDR_W-1:0] rd_addr,
    input  logic [pfp_pkg::DESC_W-1:0]     rd_data,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     status,
    output logic [7:0]                     minor_version,
    output logic [15:0]                    sequence_id,
    output logic [14:0]                    message_count,
    output logic                           descriptor_valid,
    output logic [3:0]                     message_index,
    output logic [15:0]                    payload_offset,
    output logic [15:0]                    payload_size,
    output logic [15:0]                    message_type,
    output logic                           run_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    pfp_pkg::summary_t             sum_reg;
    logic [pfp_pkg::MSG_CNT_W-1:0] k_reg;
    logic                          ovalid_reg;
    logic [2:0]                    status_reg;
    logic [7:0]                    minor_reg;
    logic [15:0]                   seq_reg;
    logic [14:0]                   count_reg;
    logic                          dvalid_reg;
    logic [3:0]                    index_reg;
    logic [15:0]                   poff_reg;
    logic [15:0]                   psize_reg;
    logic [15:0]                   ptype_reg;
    logic                          last_reg;

    logic                          slot_free;
    logic                          emit;
    logic                          is_last;
    logic [31:0]                   k_wide;
    logic [pfp_pkg::DESC_W-1:0]    desc;

    assign q_pop     = (state_reg == S_IDLE) && q_full;
    assign rd_addr   = {sum_reg.bank, k_reg[pfp_pkg::MSG_ADDR_W-1:0]};
    assign slot_free = !ovalid_reg || pop;
    assign emit      = (state_reg == S_EMIT) && slot_free;
    assign is_last   = (k_reg + pfp_pkg::MSG_CNT_W'(1)) == sum_reg.num;
    assign k_wide    = 32'(k_reg);
    assign desc      = sum_reg.desc_valid ? rd_data : '0;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            // Output slot drains on a transfer unless refilled this cycle
            if (pop && ovalid_reg && !emit)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_full)
                    begin
                        sum_reg   <= q_rdata;
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        ovalid_reg <= 1'b1;
                        status_reg <= sum_reg.status;
                        minor_reg  <= sum_reg.minor;
                        seq_reg    <= sum_reg.seq;
                        count_reg  <= sum_reg.count;
                        dvalid_reg <= sum_reg.desc_valid;
                        index_reg  <= sum_reg.desc_valid ? k_wide[3:0] : 4'd0;
                        poff_reg   <= desc[47:32];
                        psize_reg  <= desc[31:16];
                        ptype_reg  <= desc[15:0];
                        last_reg   <= is_last;
                        if (is_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            k_reg     <= k_reg + pfp_pkg::MSG_CNT_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty            = !ovalid_reg;
    assign status           = status_reg;
    assign minor_version    = minor_reg;
    assign sequence_id      = seq_reg;
    assign message_count    = count_reg;
    assign descriptor_valid = dvalid_reg;
    assign message_index    = index_reg;
    assign payload_offset   = poff_reg;
    assign payload_size     = psize_reg;
    assign message_type     = ptype_reg;
    assign run_last         = last_reg;

endmodule

FILE: sv/packet_header_and_message_parser.sv
// Top level: packet header and message parser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | push / full          | data_byte, end_of_buffer
//   result   | empty / pop          | status .. message_type, run_last
//   config   | cfg_valid / ready    | cfg_data (expected major version)
//
// Bytes are taken one per cycle while full is low. After a packet's last byte
// the front end forms the status and holds full until the summary is pushed,
// also while the summary queue is occupied. Each result takes a descriptor RAM
// read, then the output register. Two RAM banks let the next packet stream in
// while the previous one drains. Reset is asynchronous; no clearing pass is needed.
`timescale 1ns / 1ps

module packet_header_and_message_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [7:0]  minor_version,
    output logic [15:0] sequence_id,
    output logic [14:0] message_count,
    output logic        descriptor_valid,
    output logic [3:0]  message_index,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_size,
    output logic [15:0] message_type,
    output logic        run_last
);

    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    pfp_pkg::summary_t              q_wdata;
    pfp_pkg::summary_t              q_rdata;
    logic                           wr_en;
    logic [pfp_pkg::RAM_ADDR_W-1:0] wr_addr;
    logic [pfp_pkg::DESC_W-1:0]     wr_data;
    logic [pfp_pkg::RAM_ADDR_W-1:0] rd_addr;
    logic [pfp_pkg::DESC_W-1:0]     rd_data;

    pfp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_push        (q_push),
        .q_wdata       (q_wdata),
        .q_full        (q_full),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    pfp_ram #(
        .WIDTH  (pfp_pkg::DESC_W),
        .DEPTH  (pfp_pkg::RAM_DEPTH),
        .ADDR_W (pfp_pkg::RAM_ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (q_rdata)
    );

    pfp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_full           (q_full),
        .q_pop            (q_pop),
        .q_rdata          (q_rdata),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .minor_version    (minor_version),
        .sequence_id      (sequence_id),
        .message_count    (message_count),
        .descriptor_valid (descriptor_valid),
        .message_index    (message_index),
        .payload_offset   (payload_offset),
        .payload_size     (payload_size),
        .message_type     (message_type),
        .run_last         (run_last)
    );

endmodule

FILE: sv/pfp_checker.sv
// Port-level checker for the packet parser, bound to the top level.
`timescale 1ns / 1ps

module pfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic        descriptor_valid,
    input logic [3:0]  message_index,
    input logic [15:0] payload_offset,
    input logic [15:0] payload_size,
    input logic [15:0] message_type,
    input logic        run_last
);

    // An error or empty-message result stands alone
    a_nodesc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !descriptor_valid) |-> run_last)
        else $error("result without descriptor is not the last of its packet");

    // Such a result carries an all-zero descriptor
    a_nodesc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !descriptor_valid) |-> (message_index == 4'd0
            && payload_offset == 16'd0 && payload_size == 16'd0
            && message_type == 16'd0))
        else $error("descriptor fields nonzero on result without descriptor");

    // Descriptors only on good packets
    a_desc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && descriptor_valid) |-> (status == pfp_pkg::ST_OK))
        else $error("descriptor on failed packet");

    // Status stays in its code range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= pfp_pkg::ST_BAD_CRC))
        else $error("status code out of range");

    // A waiting result's status and last flag hold until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(run_last)))
        else $error("waiting result changed before transfer");

endmodule

bind packet_header_and_message_parser pfp_checker u_pfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .descriptor_valid (descriptor_valid),
    .message_index    (message_index),
    .payload_offset   (payload_offset),
    .payload_size     (payload_size),
    .message_type     (message_type),
    .run_last         (run_last)
);
